[sv/qrm_pkg.sv]
// Shared types and constants for the quaternion to rotation matrix pipeline.
package qrm_pkg;

   // Default component width (Q1.15 when 16).
   localparam int COMPONENT_WIDTH_DEFAULT = 16;

   // Number of matrix entries and their row-major positions.
   localparam int NUM_ENTRIES = 9;
   localparam int R0C0 = 0;
   localparam int R0C1 = 1;
   localparam int R0C2 = 2;
   localparam int R1C0 = 3;
   localparam int R1C1 = 4;
   localparam int R1C2 = 5;
   localparam int R2C0 = 6;
   localparam int R2C1 = 7;
   localparam int R2C2 = 8;

   // Control bits that travel down the pipeline beside each item.
   typedef struct packed {
      logic valid;
      logic zero;
   } ctrl_type;

endpackage

[sv/quaternion_to_rotation_matrix.sv]
// Quaternion to 3x3 rotation matrix: a fully pipelined datapath, one item per cycle.
//
// Usage: drive req_quat_x/y/z/w (signed Q1.W-1) and raise start; an item is
// taken at every rising edge where start is high and busy is low. busy is
// high only while reset is asserted, so an item may be offered every cycle.
// The quaternion need not be unit length; it is normalized by its squared norm.
// Each result shows on the rsp_ ports for one cycle with rsp_valid high:
// the nine entries in row-major order, Q1.W-1, rounded to nearest with ties
// away from zero and +1.0 saturated to the largest positive code. A zero
// quaternion gives the identity with rsp_zero_norm set.
// Pipeline stages from accept to rsp_valid:
// one multiply stage, one numerator/norm stage, one sign split stage,
// COMPONENT_WIDTH + 1 restoring-division steps (one quotient bit per stage,
// nine entries side by side), and one rounding and saturation stage.
// Throughput: one item per cycle, set by the step-per-stage divider.
// Reset clears all valid bits; items in flight are dropped. The receiver
// cannot stall, so results leave in accept order without backpressure.
module quaternion_to_rotation_matrix #(
   parameter int COMPONENT_WIDTH = qrm_pkg::COMPONENT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_z,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_w,
   output logic                              rsp_valid,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_rot_r0c0,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_rot_r0c1,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_rot_r0c2,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_rot_r1c0,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_rot_r1c1,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_rot_r1c2,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_rot_r2c0,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_rot_r2c1,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_rot_r2c2,
   output logic                              rsp_zero_norm
);

   localparam int W       = COMPONENT_WIDTH;
   localparam int QW      = W + 1;
   localparam int LATENCY = W + 5;
   localparam logic [W:0]   MAX_MAG = QW'((1 << (W - 1)) - 1);
   localparam logic [W-1:0] MAX_POS = MAX_MAG[W-1:0];

   logic accept;

   // The pipeline takes an item every cycle; only reset holds it off.
   assign busy   = reset;
   assign accept = start && !busy;

   qrm_pkg::ctrl_type               prep_ctrl, div_ctrl;
   logic [2*W:0]                    prep_den;
   logic [2*W:0]                    prep_mag [qrm_pkg::NUM_ENTRIES];
   logic [qrm_pkg::NUM_ENTRIES-1:0] prep_neg, div_neg;
   logic [QW-1:0]                   div_quo  [qrm_pkg::NUM_ENTRIES];

   qrm_prep #(.W(W)) u_prep (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .quat_x   (req_quat_x),
      .quat_y   (req_quat_y),
      .quat_z   (req_quat_z),
      .quat_w   (req_quat_w),
      .ctrl_out (prep_ctrl),
      .den_out  (prep_den),
      .mag_out  (prep_mag),
      .neg_out  (prep_neg)
   );

   qrm_divider #(.W(W)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl_in  (prep_ctrl),
      .den_in   (prep_den),
      .mag_in   (prep_mag),
      .neg_in   (prep_neg),
      .ctrl_out (div_ctrl),
      .quo_out  (div_quo),
      .neg_out  (div_neg)
   );

   // Output stage: round, apply the sign, saturate, or force the identity.
   logic [W:0]   mag_rnd [qrm_pkg::NUM_ENTRIES];
   logic [W-1:0] rot_in  [qrm_pkg::NUM_ENTRIES];
   logic [W-1:0] rot_ff  [qrm_pkg::NUM_ENTRIES];
   logic [W:0]   neg_val [qrm_pkg::NUM_ENTRIES];
   logic         valid_ff, zero_ff;

   always_comb begin
      for (int k = 0; k < qrm_pkg::NUM_ENTRIES; k++) begin
         mag_rnd[k] = QW'(div_quo[k][QW-1:1]) + QW'(div_quo[k][0]);
         neg_val[k] = -mag_rnd[k];
         if (div_ctrl.zero) begin
            if (k == qrm_pkg::R0C0 || k == qrm_pkg::R1C1 || k == qrm_pkg::R2C2) begin
               rot_in[k] = MAX_POS;
            end else begin
               rot_in[k] = '0;
            end
         end else if (div_neg[k]) begin
            rot_in[k] = neg_val[k][W-1:0];
         end else if (mag_rnd[k] > MAX_MAG) begin
            rot_in[k] = MAX_POS;
         end else begin
            rot_in[k] = mag_rnd[k][W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rot_ff  <= rot_in;
      zero_ff <= div_ctrl.zero && div_ctrl.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= div_ctrl.valid;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_zero_norm = zero_ff;
   assign rsp_rot_r0c0  = rot_ff[qrm_pkg::R0C0];
   assign rsp_rot_r0c1  = rot_ff[qrm_pkg::R0C1];
   assign rsp_rot_r0c2  = rot_ff[qrm_pkg::R0C2];
   assign rsp_rot_r1c0  = rot_ff[qrm_pkg::R1C0];
   assign rsp_rot_r1c1  = rot_ff[qrm_pkg::R1C1];
   assign rsp_rot_r1c2  = rot_ff[qrm_pkg::R1C2];
   assign rsp_rot_r2c0  = rot_ff[qrm_pkg::R2C0];
   assign rsp_rot_r2c1  = rot_ff[qrm_pkg::R2C1];
   assign rsp_rot_r2c2  = rot_ff[qrm_pkg::R2C2];

`ifndef ASSERT_OFF
   // Every accepted item produces a result on rsp_valid.
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("accepted item produced no result at the expected cycle");

   // No result appears without a matching accepted item.
   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result appeared without a matching accepted item");

   // A zero quaternion yields the saturated identity.
   a_identity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_norm) |-> (rsp_rot_r0c0 == MAX_POS &&
         rsp_rot_r1c1 == MAX_POS && rsp_rot_r2c2 == MAX_POS &&
         rsp_rot_r0c1 == '0 && rsp_rot_r1c2 == '0 && rsp_rot_r2c0 == '0))
      else $error("zero quaternion did not give the identity matrix");

   // The zero flag is only raised on a result cycle.
   a_flag_qual: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !rsp_zero_norm)
      else $error("zero-norm flag raised outside a result cycle");
`endif

endmodule

[sv/qrm_prep.sv]
// Front end: products, entry numerators, norm, then sign and magnitude split.
module qrm_prep #(
   parameter int W = qrm_pkg::COMPONENT_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic signed [W-1:0] quat_x,
   input  logic signed [W-1:0] quat_y,
   input  logic signed [W-1:0] quat_z,
   input  logic signed [W-1:0] quat_w,
   output qrm_pkg::ctrl_type   ctrl_out,
   output logic [2*W:0]        den_out,
   output logic [2*W:0]        mag_out [qrm_pkg::NUM_ENTRIES],
   output logic [qrm_pkg::NUM_ENTRIES-1:0] neg_out
);

   localparam int PW = 2 * W;
   localparam int DW = 2 * W + 1;
   localparam int NW = 2 * W + 2;

   qrm_pkg::ctrl_type ctrl1_ff, ctrl2_ff, ctrl3_ff;

   // Stage one: all ten products of the components.
   logic signed [PW-1:0] sq_x_in, sq_y_in, sq_z_in, sq_w_in;
   logic signed [PW-1:0] pr_xy_in, pr_wz_in, pr_xz_in, pr_wy_in, pr_yz_in, pr_wx_in;
   logic signed [PW-1:0] sq_x_ff, sq_y_ff, sq_z_ff, sq_w_ff;
   logic signed [PW-1:0] pr_xy_ff, pr_wz_ff, pr_xz_ff, pr_wy_ff, pr_yz_ff, pr_wx_ff;
   logic                 zero_in;

   assign sq_x_in  = quat_x * quat_x;
   assign sq_y_in  = quat_y * quat_y;
   assign sq_z_in  = quat_z * quat_z;
   assign sq_w_in  = quat_w * quat_w;
   assign pr_xy_in = quat_x * quat_y;
   assign pr_wz_in = quat_w * quat_z;
   assign pr_xz_in = quat_x * quat_z;
   assign pr_wy_in = quat_w * quat_y;
   assign pr_yz_in = quat_y * quat_z;
   assign pr_wx_in = quat_w * quat_x;
   assign zero_in  = (quat_x == '0) && (quat_y == '0) && (quat_z == '0) && (quat_w == '0);

   always_ff @(posedge clock) begin
      sq_x_ff  <= sq_x_in;
      sq_y_ff  <= sq_y_in;
      sq_z_ff  <= sq_z_in;
      sq_w_ff  <= sq_w_in;
      pr_xy_ff <= pr_xy_in;
      pr_wz_ff <= pr_wz_in;
      pr_xz_ff <= pr_xz_in;
      pr_wy_ff <= pr_wy_in;
      pr_yz_ff <= pr_yz_in;
      pr_wx_ff <= pr_wx_in;
   end

   // Stage two: signed numerators of the nine entries and the squared norm.
   logic signed [NW-1:0] num_in [qrm_pkg::NUM_ENTRIES];
   logic signed [NW-1:0] num_ff [qrm_pkg::NUM_ENTRIES];
   logic signed [NW-1:0] den_sum;
   logic [DW-1:0]        den2_ff;

   always_comb begin
      num_in[qrm_pkg::R0C0] = NW'(sq_x_ff) + NW'(sq_w_ff) - NW'(sq_y_ff) - NW'(sq_z_ff);
      num_in[qrm_pkg::R1C1] = NW'(sq_y_ff) + NW'(sq_w_ff) - NW'(sq_x_ff) - NW'(sq_z_ff);
      num_in[qrm_pkg::R2C2] = NW'(sq_z_ff) + NW'(sq_w_ff) - NW'(sq_x_ff) - NW'(sq_y_ff);
      num_in[qrm_pkg::R0C1] = (NW'(pr_xy_ff) + NW'(pr_wz_ff)) <<< 1;
      num_in[qrm_pkg::R1C0] = (NW'(pr_xy_ff) - NW'(pr_wz_ff)) <<< 1;
      num_in[qrm_pkg::R0C2] = (NW'(pr_xz_ff) - NW'(pr_wy_ff)) <<< 1;
      num_in[qrm_pkg::R2C0] = (NW'(pr_xz_ff) + NW'(pr_wy_ff)) <<< 1;
      num_in[qrm_pkg::R1C2] = (NW'(pr_yz_ff) + NW'(pr_wx_ff)) <<< 1;
      num_in[qrm_pkg::R2C1] = (NW'(pr_yz_ff) - NW'(pr_wx_ff)) <<< 1;
      den_sum = NW'(sq_x_ff) + NW'(sq_y_ff) + NW'(sq_z_ff) + NW'(sq_w_ff);
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den2_ff <= den_sum[DW-1:0];
   end

   // Stage three: split each numerator into sign and magnitude.
   // Every magnitude is at most the norm, so it fits the norm's width.
   logic [DW-1:0]                   mag_in [qrm_pkg::NUM_ENTRIES];
   logic [DW-1:0]                   mag_ff [qrm_pkg::NUM_ENTRIES];
   logic [qrm_pkg::NUM_ENTRIES-1:0] neg_in, neg_ff;
   logic [DW-1:0]                   den3_ff;
   logic signed [NW-1:0]            abs_val [qrm_pkg::NUM_ENTRIES];

   always_comb begin
      for (int k = 0; k < qrm_pkg::NUM_ENTRIES; k++) begin
         neg_in[k]  = num_ff[k][NW-1];
         abs_val[k] = neg_in[k] ? -num_ff[k] : num_ff[k];
         mag_in[k]  = abs_val[k][DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      den3_ff <= den2_ff;
   end

   // Control travels with the data through all three stages; only valid is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff.valid <= 1'b0;
         ctrl2_ff.valid <= 1'b0;
         ctrl3_ff.valid <= 1'b0;
      end else begin
         ctrl1_ff.valid <= in_valid;
         ctrl2_ff.valid <= ctrl1_ff.valid;
         ctrl3_ff.valid <= ctrl2_ff.valid;
      end
      ctrl1_ff.zero <= zero_in;
      ctrl2_ff.zero <= ctrl1_ff.zero;
      ctrl3_ff.zero <= ctrl2_ff.zero;
   end

   assign ctrl_out = ctrl3_ff;
   assign den_out  = den3_ff;
   assign mag_out  = mag_ff;
   assign neg_out  = neg_ff;

endmodule

[sv/qrm_div_step.sv]
// One restoring-division step for all nine entries, registered.
module qrm_div_step #(
   parameter int W = qrm_pkg::COMPONENT_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  qrm_pkg::ctrl_type               ctrl_in,
   input  logic [2*W:0]                    den_in,
   input  logic [2*W+1:0]                  rem_in [qrm_pkg::NUM_ENTRIES],
   input  logic [W:0]                      quo_in [qrm_pkg::NUM_ENTRIES],
   input  logic [qrm_pkg::NUM_ENTRIES-1:0] neg_in,
   output qrm_pkg::ctrl_type               ctrl_out,
   output logic [2*W:0]                    den_out,
   output logic [2*W+1:0]                  rem_out [qrm_pkg::NUM_ENTRIES],
   output logic [W:0]                      quo_out [qrm_pkg::NUM_ENTRIES],
   output logic [qrm_pkg::NUM_ENTRIES-1:0] neg_out
);

   localparam int RW = 2 * W + 2;
   localparam int QW = W + 1;

   logic [RW-1:0] rem_nxt [qrm_pkg::NUM_ENTRIES];
   logic [QW-1:0] quo_nxt [qrm_pkg::NUM_ENTRIES];
   logic [RW-1:0] rem_ff  [qrm_pkg::NUM_ENTRIES];
   logic [QW-1:0] quo_ff  [qrm_pkg::NUM_ENTRIES];
   logic [RW-1:0] diff    [qrm_pkg::NUM_ENTRIES];
   logic [qrm_pkg::NUM_ENTRIES-1:0] ge;
   logic [qrm_pkg::NUM_ENTRIES-1:0] neg_ff;
   logic [2*W:0]                    den_ff;
   qrm_pkg::ctrl_type               ctrl_ff;

   // Compare against the norm, subtract when it fits, shift for the next bit.
   always_comb begin
      for (int k = 0; k < qrm_pkg::NUM_ENTRIES; k++) begin
         ge[k]      = rem_in[k] >= RW'(den_in);
         diff[k]    = ge[k] ? (rem_in[k] - RW'(den_in)) : rem_in[k];
         rem_nxt[k] = {diff[k][RW-2:0], 1'b0};
         quo_nxt[k] = {quo_in[k][QW-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_nxt;
      quo_ff <= quo_nxt;
      neg_ff <= neg_in;
      den_ff <= den_in;
   end

   // Control bits move with the data; only valid is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      ctrl_ff.zero <= ctrl_in.zero;
   end

   assign ctrl_out = ctrl_ff;
   assign den_out  = den_ff;
   assign rem_out  = rem_ff;
   assign quo_out  = quo_ff;
   assign neg_out  = neg_ff;

endmodule

[sv/qrm_divider.sv]
// Chain of division steps: quotient bits of magnitude over norm, plus a round bit.
module qrm_divider #(
   parameter int W = qrm_pkg::COMPONENT_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  qrm_pkg::ctrl_type               ctrl_in,
   input  logic [2*W:0]                    den_in,
   input  logic [2*W:0]                    mag_in [qrm_pkg::NUM_ENTRIES],
   input  logic [qrm_pkg::NUM_ENTRIES-1:0] neg_in,
   output qrm_pkg::ctrl_type               ctrl_out,
   output logic [W:0]                      quo_out [qrm_pkg::NUM_ENTRIES],
   output logic [qrm_pkg::NUM_ENTRIES-1:0] neg_out
);

   localparam int RW     = 2 * W + 2;
   localparam int QW     = W + 1;
   // One integer bit, W-1 fraction bits, then one round bit.
   localparam int DSTEPS = W + 1;

   qrm_pkg::ctrl_type               ctrl_s [DSTEPS+1];
   logic [2*W:0]                    den_s  [DSTEPS+1];
   logic [RW-1:0]                   rem_s  [DSTEPS+1][qrm_pkg::NUM_ENTRIES];
   logic [QW-1:0]                   quo_s  [DSTEPS+1][qrm_pkg::NUM_ENTRIES];
   logic [qrm_pkg::NUM_ENTRIES-1:0] neg_s  [DSTEPS+1];

   // The magnitude never exceeds the norm, so the first step yields one bit.
   assign ctrl_s[0] = ctrl_in;
   assign den_s[0]  = den_in;
   assign neg_s[0]  = neg_in;

   for (genvar k = 0; k < qrm_pkg::NUM_ENTRIES; k++) begin : g_load
      assign rem_s[0][k] = RW'(mag_in[k]);
      assign quo_s[0][k] = '0;
   end

   for (genvar i = 0; i < DSTEPS; i++) begin : g_step
      qrm_div_step #(.W(W)) u_step (
         .clock    (clock),
         .reset    (reset),
         .ctrl_in  (ctrl_s[i]),
         .den_in   (den_s[i]),
         .rem_in   (rem_s[i]),
         .quo_in   (quo_s[i]),
         .neg_in   (neg_s[i]),
         .ctrl_out (ctrl_s[i+1]),
         .den_out  (den_s[i+1]),
         .rem_out  (rem_s[i+1]),
         .quo_out  (quo_s[i+1]),
         .neg_out  (neg_s[i+1])
      );
   end

   assign ctrl_out = ctrl_s[DSTEPS];
   assign quo_out  = quo_s[DSTEPS];
   assign neg_out  = neg_s[DSTEPS];

endmodule

[tb/tb_quaternion_to_rotation_matrix.sv]
// Testbench for the quaternion to rotation matrix pipeline, with its own predictor and checker.
`timescale 1ns / 1ps

module tb_quaternion_to_rotation_matrix;

   localparam int W = qrm_pkg::COMPONENT_WIDTH_DEFAULT;
   localparam int LATENCY = W + 5;
   localparam logic signed [W-1:0] POS_ONE = W'((1 <<< (W - 1)) - 1);
   localparam logic signed [W-1:0] NEG_ONE = W'(-(1 <<< (W - 1)));
   localparam int NUM_RANDOM = 500;

   // One matrix with its zero flag, as it leaves the block.
   typedef struct packed {
      logic [qrm_pkg::NUM_ENTRIES-1:0][W-1:0] ent;
      logic                                   zero_norm;
   } rot_type;

   // One row of the directed table; a known row carries a diagonal matrix.
   typedef struct {
      logic signed [W-1:0] x;
      logic signed [W-1:0] y;
      logic signed [W-1:0] z;
      logic signed [W-1:0] w;
      bit                  known;
      logic signed [W-1:0] d0;
      logic signed [W-1:0] d1;
      logic signed [W-1:0] d2;
      bit                  zero_norm;
   } quat_row_type;

   // Ways of drawing one random component.
   typedef enum int {CM_FULL, CM_EXTREME, CM_SMALL, CM_SCALED} comp_mode_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic signed [W-1:0] req_quat_x;
   logic signed [W-1:0] req_quat_y;
   logic signed [W-1:0] req_quat_z;
   logic signed [W-1:0] req_quat_w;
   logic                rsp_valid;
   logic signed [W-1:0] rsp_rot_r0c0;
   logic signed [W-1:0] rsp_rot_r0c1;
   logic signed [W-1:0] rsp_rot_r0c2;
   logic signed [W-1:0] rsp_rot_r1c0;
   logic signed [W-1:0] rsp_rot_r1c1;
   logic signed [W-1:0] rsp_rot_r1c2;
   logic signed [W-1:0] rsp_rot_r2c0;
   logic signed [W-1:0] rsp_rot_r2c1;
   logic signed [W-1:0] rsp_rot_r2c2;
   logic                rsp_zero_norm;

   rot_type      pending_mats[$];
   int           errors = 0;
   int           items_sent = 0;
   int           mats_checked = 0;
   int           zero_quats = 0;
   int           burst_left = 0;
   quat_row_type quat_table[20];

   string entry_name[qrm_pkg::NUM_ENTRIES] = '{"rot_r0c0", "rot_r0c1", "rot_r0c2",
                                               "rot_r1c0", "rot_r1c1", "rot_r1c2",
                                               "rot_r2c0", "rot_r2c1", "rot_r2c2"};

   quaternion_to_rotation_matrix #(
      .COMPONENT_WIDTH(W)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_quat_x   (req_quat_x),
      .req_quat_y   (req_quat_y),
      .req_quat_z   (req_quat_z),
      .req_quat_w   (req_quat_w),
      .rsp_valid    (rsp_valid),
      .rsp_rot_r0c0 (rsp_rot_r0c0),
      .rsp_rot_r0c1 (rsp_rot_r0c1),
      .rsp_rot_r0c2 (rsp_rot_r0c2),
      .rsp_rot_r1c0 (rsp_rot_r1c0),
      .rsp_rot_r1c1 (rsp_rot_r1c1),
      .rsp_rot_r1c2 (rsp_rot_r1c2),
      .rsp_rot_r2c0 (rsp_rot_r2c0),
      .rsp_rot_r2c1 (rsp_rot_r2c1),
      .rsp_rot_r2c2 (rsp_rot_r2c2),
      .rsp_zero_norm(rsp_zero_norm)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #5ms;
      $display("tb_quaternion_to_rotation_matrix: errors");
      $finish;
   end

   // One entry num/n scaled to Q1.(W-1), rounded half away from zero, saturated.
   function automatic logic [W-1:0] scaled_entry(longint num, longint n);
      longint one_q;
      longint m;
      longint q;
      longint v;
      one_q = longint'(1) <<< (W - 1);
      m = (num < 0) ? -num : num;
      q = (2 * m * one_q + n) / (2 * n);
      v = (num < 0) ? -q : q;
      if (v > one_q - 1) v = one_q - 1;
      if (v < -one_q) v = -one_q;
      return v[W-1:0];
   endfunction

   // Rotation matrix of a quaternion, normalized by its squared norm.
   function automatic rot_type rotation_of(logic signed [W-1:0] qx, logic signed [W-1:0] qy,
                                           logic signed [W-1:0] qz, logic signed [W-1:0] qw);
      rot_type r;
      longint  x;
      longint  y;
      longint  z;
      longint  w;
      longint  n;
      x = qx;
      y = qy;
      z = qz;
      w = qw;
      n = x * x + y * y + z * z + w * w;
      r = '0;
      if (n == 0) begin
         r.ent[qrm_pkg::R0C0] = POS_ONE;
         r.ent[qrm_pkg::R1C1] = POS_ONE;
         r.ent[qrm_pkg::R2C2] = POS_ONE;
         r.zero_norm = 1'b1;
         return r;
      end
      r.ent[qrm_pkg::R0C0] = scaled_entry(x * x + w * w - y * y - z * z, n);
      r.ent[qrm_pkg::R0C1] = scaled_entry(2 * (x * y + w * z), n);
      r.ent[qrm_pkg::R0C2] = scaled_entry(2 * (x * z - w * y), n);
      r.ent[qrm_pkg::R1C0] = scaled_entry(2 * (x * y - w * z), n);
      r.ent[qrm_pkg::R1C1] = scaled_entry(y * y + w * w - x * x - z * z, n);
      r.ent[qrm_pkg::R1C2] = scaled_entry(2 * (y * z + w * x), n);
      r.ent[qrm_pkg::R2C0] = scaled_entry(2 * (x * z + w * y), n);
      r.ent[qrm_pkg::R2C1] = scaled_entry(2 * (y * z - w * x), n);
      r.ent[qrm_pkg::R2C2] = scaled_entry(z * z + w * w - x * x - y * y, n);
      return r;
   endfunction

   // Idle length before the next item: mostly short, a few long, some bursts with none.
   function automatic int next_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // One random component drawn in the given way.
   function automatic logic signed [W-1:0] pick_component(comp_mode_type mode);
      logic signed [W-1:0] raw;
      raw = W'($urandom);
      case (mode)
         CM_EXTREME: begin
            case ($urandom_range(0, 4))
               0: return NEG_ONE;
               1: return POS_ONE;
               2: return '0;
               3: return W'(1);
               default: return '1;
            endcase
         end
         CM_SMALL: return W'($urandom_range(0, 16) - 8);
         CM_SCALED: return raw >>> $urandom_range(1, 14);
         default: return raw;
      endcase
   endfunction

   // Offer one item, wait for it to be taken, record its expected matrix, then idle.
   task automatic send_quat(logic signed [W-1:0] x, logic signed [W-1:0] y,
                            logic signed [W-1:0] z, logic signed [W-1:0] w,
                            rot_type exp_mat);
      int gap;
      @(negedge clock);
      req_quat_x = x;
      req_quat_y = y;
      req_quat_z = z;
      req_quat_w = w;
      start = 1'b1;
      do @(posedge clock); while (busy);
      pending_mats.push_back(exp_mat);
      items_sent++;
      if (exp_mat.zero_norm) zero_quats++;
      gap = next_gap();
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         req_quat_x = W'($urandom);
         req_quat_y = W'($urandom);
         req_quat_z = W'($urandom);
         req_quat_w = W'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Compare each result with the oldest expected matrix.
   always @(posedge clock) begin
      rot_type got;
      rot_type exp_mat;
      if (rsp_valid) begin
         got.ent[qrm_pkg::R0C0] = rsp_rot_r0c0;
         got.ent[qrm_pkg::R0C1] = rsp_rot_r0c1;
         got.ent[qrm_pkg::R0C2] = rsp_rot_r0c2;
         got.ent[qrm_pkg::R1C0] = rsp_rot_r1c0;
         got.ent[qrm_pkg::R1C1] = rsp_rot_r1c1;
         got.ent[qrm_pkg::R1C2] = rsp_rot_r1c2;
         got.ent[qrm_pkg::R2C0] = rsp_rot_r2c0;
         got.ent[qrm_pkg::R2C1] = rsp_rot_r2c1;
         got.ent[qrm_pkg::R2C2] = rsp_rot_r2c2;
         got.zero_norm = rsp_zero_norm;
         if (pending_mats.size() == 0) begin
            $error("matrix with no item waiting for it");
            errors++;
         end else begin
            exp_mat = pending_mats.pop_front();
            mats_checked++;
            for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++) begin
               if (got.ent[i] !== exp_mat.ent[i]) begin
                  $error("%s: expected %0d, got %0d", entry_name[i],
                         $signed(exp_mat.ent[i]), $signed(got.ent[i]));
                  errors++;
               end
            end
            if (got.zero_norm !== exp_mat.zero_norm) begin
               $error("zero_norm: expected %0d, got %0d", exp_mat.zero_norm, got.zero_norm);
               errors++;
            end
         end
      end
   end

   // Reset, directed table, random items, drain and verdict.
   initial begin
      rot_type             exp_mat;
      logic signed [W-1:0] q[4];
      int                  kind;
      int                  drain;

      reset = 1'b1;
      start = 1'b0;
      req_quat_x = '0;
      req_quat_y = '0;
      req_quat_z = '0;
      req_quat_w = '0;

      // Zero quaternion, single-axis extremes, identities, and a spread of mixed rows.
      quat_table[0]  = '{0, 0, 0, 0, 1'b1, POS_ONE, POS_ONE, POS_ONE, 1'b1};
      quat_table[1]  = '{POS_ONE, 0, 0, 0, 1'b1, POS_ONE, NEG_ONE, NEG_ONE, 1'b0};
      quat_table[2]  = '{NEG_ONE, 0, 0, 0, 1'b1, POS_ONE, NEG_ONE, NEG_ONE, 1'b0};
      quat_table[3]  = '{0, POS_ONE, 0, 0, 1'b1, NEG_ONE, POS_ONE, NEG_ONE, 1'b0};
      quat_table[4]  = '{0, NEG_ONE, 0, 0, 1'b1, NEG_ONE, POS_ONE, NEG_ONE, 1'b0};
      quat_table[5]  = '{0, 0, NEG_ONE, 0, 1'b1, NEG_ONE, NEG_ONE, POS_ONE, 1'b0};
      quat_table[6]  = '{0, 0, 1, 0, 1'b1, NEG_ONE, NEG_ONE, POS_ONE, 1'b0};
      quat_table[7]  = '{0, 0, 0, POS_ONE, 1'b1, POS_ONE, POS_ONE, POS_ONE, 1'b0};
      quat_table[8]  = '{0, 0, 0, NEG_ONE, 1'b1, POS_ONE, POS_ONE, POS_ONE, 1'b0};
      quat_table[9]  = '{0, 0, 0, 1, 1'b1, POS_ONE, POS_ONE, POS_ONE, 1'b0};
      quat_table[10] = '{1, 0, 0, 0, 1'b1, POS_ONE, NEG_ONE, NEG_ONE, 1'b0};
      quat_table[11] = '{NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE, 1'b0, 0, 0, 0, 1'b0};
      quat_table[12] = '{POS_ONE, POS_ONE, POS_ONE, POS_ONE, 1'b0, 0, 0, 0, 1'b0};
      quat_table[13] = '{POS_ONE, NEG_ONE, POS_ONE, NEG_ONE, 1'b0, 0, 0, 0, 1'b0};
      quat_table[14] = '{1, 1, 1, 1, 1'b0, 0, 0, 0, 1'b0};
      quat_table[15] = '{-1, 0, 0, 1, 1'b0, 0, 0, 0, 1'b0};
      quat_table[16] = '{16384, 0, 0, 16384, 1'b0, 0, 0, 0, 1'b0};
      quat_table[17] = '{21845, -21846, 10922, 5461, 1'b0, 0, 0, 0, 1'b0};
      quat_table[18] = '{12345, -2345, 30000, -7, 1'b0, 0, 0, 0, 1'b0};
      quat_table[19] = '{3, -5, 7, 2, 1'b0, 0, 0, 0, 1'b0};

      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Directed rows: typed-in diagonals where known, predictor elsewhere.
      foreach (quat_table[i]) begin
         if (quat_table[i].known) begin
            exp_mat = '0;
            exp_mat.ent[qrm_pkg::R0C0] = quat_table[i].d0;
            exp_mat.ent[qrm_pkg::R1C1] = quat_table[i].d1;
            exp_mat.ent[qrm_pkg::R2C2] = quat_table[i].d2;
            exp_mat.zero_norm = quat_table[i].zero_norm;
         end else begin
            exp_mat = rotation_of(quat_table[i].x, quat_table[i].y,
                                  quat_table[i].z, quat_table[i].w);
         end
         send_quat(quat_table[i].x, quat_table[i].y, quat_table[i].z, quat_table[i].w,
                   exp_mat);
      end

      // Random items: mostly mixed component styles, some zero or single-axis quaternions.
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if ($urandom_range(0, 79) == 0) burst_left = $urandom_range(20, 50);
         kind = $urandom_range(0, 99);
         if (kind < 3) begin
            foreach (q[k]) q[k] = '0;
         end else if (kind < 10) begin
            foreach (q[k]) q[k] = '0;
            q[$urandom_range(0, 3)] = pick_component(CM_FULL);
         end else begin
            foreach (q[k]) q[k] = pick_component(comp_mode_type'($urandom_range(0, 3)));
         end
         send_quat(q[0], q[1], q[2], q[3], rotation_of(q[0], q[1], q[2], q[3]));
      end

      @(negedge clock);
      start = 1'b0;

      // Wait for the pipeline to empty, then a little longer for stray results.
      drain = 0;
      while (pending_mats.size() != 0 && drain < 10 * LATENCY) begin
         @(posedge clock);
         drain++;
      end
      repeat (LATENCY + 5) @(posedge clock);
      if (pending_mats.size() != 0) begin
         $error("%0d expected matrices never arrived", pending_mats.size());
         errors++;
      end

      $display("Sent %0d quaternions (%0d of them zero) and checked %0d matrices.",
               items_sent, zero_quats, mats_checked);
      $display("Stimulus mixed extremes, small and scaled components under random idle gaps.");
      if (errors == 0) begin
         $display("tb_quaternion_to_rotation_matrix: clean");
      end else begin
         $display("tb_quaternion_to_rotation_matrix: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/qrm_pkg.sv
sv/qrm_prep.sv
sv/qrm_div_step.sv
sv/qrm_divider.sv
sv/quaternion_to_rotation_matrix.sv
tb/tb_quaternion_to_rotation_matrix.sv
